// File: sv/assert_macros.svh
// assertion helpers for the frame decoder
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in a cycle -> consequent holds in the same cycle
`define SFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfd check failed");

// antecedent holds in a cycle -> consequent holds in the next cycle
`define SFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfd check failed");

`endif

// File: sv/sfd_pkg.sv
// shared constants, crc-8 step function and controller/datapath bundles
// no dependencies
package sfd_pkg;

  localparam int BYTE_W       = 8;
  localparam int PLEN_W       = 6;
  localparam int FRAME_BUF_DEF = 64;
  localparam int OVERHEAD     = 5;
  localparam int PAYLOAD_OFS  = 4;

  localparam logic [BYTE_W-1:0] HEAD_CODE = 8'hAB;
  localparam logic [BYTE_W-1:0] TAIL_CODE = 8'hCD;
  localparam logic [BYTE_W-1:0] PAD_CODE  = 8'hEA;
  localparam logic [BYTE_W-1:0] CRC_POLY  = 8'h07;

  // index of the header fields within the collected frame
  localparam int ID_IDX  = 1;
  localparam int LEN_IDX = 2;
  localparam int CRC_IDX = 3;

  typedef struct packed {
    logic rx_en;     // accept one raw byte
    logic k_clr;     // restart the payload index
    logic crc_init;  // seed crc with the frame id
    logic rd_en;     // read payload byte at the index, advance index
    logic crc_mode;  // read data feeds the crc
    logic out_load;  // read data goes to the output register
  } sfd_cmd_t;

  typedef struct packed {
    logic close_ok;   // accepted byte closes a frame of consistent length
    logic rd_last;    // read at the index is the last payload byte
    logic emit_last;  // byte loaded now is the last payload byte
    logic crc_ok;     // computed crc equals the frame crc
    logic out_free;   // output register can take a beat
  } sfd_sts_t;

  // one byte of crc-8, msb first
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      else c = {c[BYTE_W-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: sv/sfd_in_if.sv
// input channel: raw received byte with valid/ready
// depends on sfd_pkg
interface sfd_in_if;
  import sfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: sv/sfd_out_if.sv
// result channel: payload byte of a validated frame with valid/ready
// depends on sfd_pkg
interface sfd_out_if;
  import sfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic [BYTE_W-1:0] frame_id;
  logic [PLEN_W-1:0] payload_length;
  logic              last_byte;

  modport source (output valid, output payload_byte, output frame_id,
                  output payload_length, output last_byte, input ready);
  modport sink (input valid, input payload_byte, input frame_id,
                input payload_length, input last_byte, output ready);
endinterface

// File: sv/sfd_ctrl.sv
// sequencing fsm: collect, crc check over the stored payload, payload read-out
// depends on sfd_pkg
module sfd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sfd_pkg::sfd_sts_t sts,
  output sfd_pkg::sfd_cmd_t cmd
);
  import sfd_pkg::*;

  localparam logic [2:0] S_RX   = 3'd0;
  localparam logic [2:0] S_CRC  = 3'd1;
  localparam logic [2:0] S_CEND = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_ERD  = 3'd4;
  localparam logic [2:0] S_ELD  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_RX: begin
        in_ready   = 1'b1;
        cmd.rx_en  = in_valid;
        if (sts.close_ok) begin
          cmd.crc_init = 1'b1;
          cmd.k_clr    = 1'b1;
          state_nxt    = S_CRC;
        end
      end
      S_CRC: begin
        // one read per cycle, data is consumed in the cycle after the read
        cmd.rd_en    = 1'b1;
        cmd.crc_mode = 1'b1;
        if (sts.rd_last) state_nxt = S_CEND;
      end
      S_CEND: begin
        cmd.crc_mode = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        if (sts.crc_ok) begin
          cmd.k_clr = 1'b1;
          state_nxt = S_ERD;
        end else begin
          state_nxt = S_RX;
        end
      end
      S_ERD: begin
        if (sts.out_free) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_ELD;
        end
      end
      S_ELD: begin
        cmd.out_load = 1'b1;
        state_nxt    = sts.emit_last ? S_RX : S_ERD;
      end
      default: state_nxt = S_RX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_RX;
    else state_r <= state_nxt;
  end

endmodule

// File: sv/sfd_dp.sv
// datapath: unstuffing, frame store, header capture, crc register,
// output register. depends on sfd_pkg
module sfd_dp #(
  parameter int FRAME_BUF = sfd_pkg::FRAME_BUF_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [sfd_pkg::BYTE_W-1:0] rx_byte,
  input  sfd_pkg::sfd_cmd_t         cmd,
  output sfd_pkg::sfd_sts_t         sts,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [sfd_pkg::BYTE_W-1:0] payload_byte,
  output logic [sfd_pkg::BYTE_W-1:0] frame_id,
  output logic [sfd_pkg::PLEN_W-1:0] payload_length,
  output logic                      last_byte
);
  import sfd_pkg::*;

  localparam int AW = $clog2(FRAME_BUF);
  localparam int CW = $clog2(FRAME_BUF + 1);

  logic [BYTE_W-1:0] mem [FRAME_BUF];

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic              esc_r, esc_nxt;
  logic [BYTE_W-1:0] id_r, len_r, crcf_r;
  logic [AW-1:0]     k_r;
  logic [BYTE_W-1:0] crc_r;
  logic [BYTE_W-1:0] rdata_r;
  logic              rvalid_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [BYTE_W-1:0] out_id_r;
  logic [PLEN_W-1:0] out_len_r;
  logic              out_last_r;

  logic              wr_en;
  logic [AW-1:0]     wr_idx;
  logic [AW-1:0]     rd_idx;
  logic              close;
  logic              size_ok;
  logic [CW-1:0]     n_tot;

  // byte unstuffing and frame bookkeeping
  always_comb begin
    cnt_nxt      = cnt_r;
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    wr_en        = 1'b0;
    wr_idx       = cnt_r[AW-1:0];
    close        = 1'b0;
    if (cmd.rx_en) begin
      if (in_frame_r && esc_r) begin
        wr_en   = 1'b1;
        esc_nxt = 1'b0;
        cnt_nxt = cnt_r + CW'(1);
      end else if (rx_byte == PAD_CODE) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        if (rx_byte == HEAD_CODE) begin
          wr_en        = 1'b1;
          wr_idx       = '0;
          cnt_nxt      = CW'(1);
          in_frame_nxt = 1'b1;
        end else if (in_frame_r) begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
          close   = (rx_byte == TAIL_CODE);
        end
      end
      if (close || (in_frame_nxt && cnt_nxt >= CW'(FRAME_BUF))) begin
        in_frame_nxt = 1'b0;
        esc_nxt      = 1'b0;
        cnt_nxt      = '0;
      end
    end
  end

  // length check on the closing beat
  assign n_tot   = cnt_r + CW'(1);
  assign size_ok = (n_tot > CW'(OVERHEAD)) &&
                   ((9'(len_r) + 9'(OVERHEAD)) == 9'(n_tot));

  assign rd_idx = AW'(PAYLOAD_OFS) + k_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= rx_byte;
    if (cmd.rd_en) rdata_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_idx == AW'(ID_IDX)) id_r <= rx_byte;
    if (wr_en && wr_idx == AW'(LEN_IDX)) len_r <= rx_byte;
    if (wr_en && wr_idx == AW'(CRC_IDX)) crcf_r <= rx_byte;
    if (cmd.crc_init) crc_r <= id_r;
    else if (rvalid_r && cmd.crc_mode) crc_r <= crc8_byte(crc_r, rdata_r);
    // header fields travel with the beat, a new frame may start while it waits
    if (cmd.out_load) begin
      out_byte_r <= rdata_r;
      out_id_r   <= id_r;
      out_len_r  <= len_r[PLEN_W-1:0];
      out_last_r <= (8'(k_r) == len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      in_frame_r  <= 1'b0;
      esc_r       <= 1'b0;
      k_r         <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      rvalid_r   <= cmd.rd_en;
      if (cmd.k_clr) k_r <= '0;
      else if (cmd.rd_en) k_r <= k_r + AW'(1);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign sts.close_ok  = close && size_ok;
  assign sts.rd_last   = ((8'(k_r) + 8'd1) == len_r);
  assign sts.emit_last = (8'(k_r) == len_r);
  assign sts.crc_ok    = (crc_r == crcf_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign payload_byte   = out_byte_r;
  assign frame_id       = out_id_r;
  assign payload_length = out_len_r;
  assign last_byte      = out_last_r;

endmodule

// File: sv/stuffed_frame_decoder_crc8.sv
// collecting: one raw byte accepted per cycle, no result until a tail beat
// after a tail: crc over the stored payload, seeded with the frame id, one stored byte per cycle
// first payload beat valid only after the crc compare matches
// read-out: per payload byte one store read, once the output register is free, then one output load
// input is held off from the tail until the last payload byte is loaded, or until a crc mismatch
// reset (sync, active low) clears the fsm, counters and flags, not the store or data registers
`include "assert_macros.svh"
module stuffed_frame_decoder_crc8 #(
  parameter int FRAME_BUF = sfd_pkg::FRAME_BUF_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sfd_in_if.sink     in_if,
  sfd_out_if.source  out_if
);
  import sfd_pkg::*;

  sfd_cmd_t cmd;
  sfd_sts_t sts;

  sfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfd_dp #(.FRAME_BUF(FRAME_BUF)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_byte        (in_if.rx_byte),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_if.ready),
    .out_valid      (out_if.valid),
    .payload_byte   (out_if.payload_byte),
    .frame_id       (out_if.frame_id),
    .payload_length (out_if.payload_length),
    .last_byte      (out_if.last_byte)
  );

  // collection and store read-out never share a cycle
  `SFD_ASSERT_SAME(a_rx_rd_excl, clk, rst_n, cmd.rx_en, !cmd.rd_en && !cmd.out_load)
  // a closing frame stops intake for the check
  `SFD_ASSERT_NEXT(a_close_stall, clk, rst_n, cmd.crc_init, !in_if.ready)
  // a loaded beat shows up on the result channel
  `SFD_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.out_load, out_if.valid)

endmodule
